FILE: sv/straight_line_trapezoid_trajectory_macros.svh
// assertion macros used by the waypoint sequencer (slt_gen)
`ifndef STRAIGHT_LINE_TRAPEZOID_TRAJECTORY_MACROS_SVH
`define STRAIGHT_LINE_TRAPEZOID_TRAJECTORY_MACROS_SVH

// property checked at every clock edge out of reset
`define SLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence checked in the cycle after the trigger
`define SLT_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

FILE: sv/slt_pkg.sv
// shared types, constants and arithmetic helpers of the trajectory block
`default_nettype none
package slt_pkg;

  localparam int MaxPoints = 64;
  localparam int DenW      = $clog2(MaxPoints);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRUISE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACCEL   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRAP_MODE   = 3'd4;

  localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
  localparam logic [15:0] PI_Q13      = 16'd25736;

  localparam int CordicSteps = 16;
  localparam logic [15:0] CORDIC_ANGLE [CordicSteps] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  typedef struct packed {
    logic [6:0]  point_count;
    logic [9:0]  time_step_ms;
    logic [15:0] cruise_velocity;
    logic [15:0] max_accel;
    logic        trapezoid_mode;
  } cfg_t;

  // everything the waypoint sequencer needs for one run
  typedef struct packed {
    logic [31:0]     sx;
    logic [31:0]     sy;
    logic            neg_x;
    logic            neg_y;
    logic [32:0]     qx;
    logic [DenW-1:0] rx;
    logic [32:0]     qy;
    logic [DenW-1:0] ry;
    logic [32:0]     qd;
    logic [DenW-1:0] rd;
    logic [32:0]     span;
    logic [15:0]     heading;
    logic            triangle;
    logic [DenW-1:0] den;
    logic [31:0]     vv;
  } run_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [32:0] root;
  } isq_t;

  // one digit of a restoring square root
  function automatic isq_t isq_step(input logic [35:0] rem, input logic [1:0] pair,
                                    input logic [32:0] root);
    logic [35:0] r2;
    logic [35:0] trial;
    isq_t        res;
    r2    = {rem[33:0], pair};
    trial = {1'b0, root, 2'b01};
    if (r2 >= trial) begin
      res.rem  = r2 - trial;
      res.root = {root[31:0], 1'b1};
    end else begin
      res.rem  = r2;
      res.root = {root[31:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [15:0] eff_accel(input logic [15:0] a);
    return (a == 16'd0) ? 16'd1 : a;
  endfunction

  function automatic logic [DenW-1:0] run_den(input logic [6:0] pc);
    logic [6:0] n;
    if (pc < 7'd2) begin
      n = 7'd2;
    end else if (pc > 7'(MaxPoints)) begin
      n = 7'(MaxPoints);
    end else begin
      n = pc;
    end
    return DenW'(n - 7'd1);
  endfunction

endpackage
`default_nettype wire

FILE: sv/slt_setup.sv
// per-request setup: distance, heading and step quotients for one run
`default_nettype none
module slt_setup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   start_x_i,
  input  logic [31:0]   start_y_i,
  input  logic [31:0]   goal_x_i,
  input  logic [31:0]   goal_y_i,
  output logic          par_valid_o,
  input  logic          par_ready_i,
  output slt_pkg::run_t par_o
);
  import slt_pkg::*;

  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 33;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;
  localparam logic [2:0] S_SQY  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_TRI  = 3'd5;

  localparam logic [1:0] CD_NORM = 2'd0;
  localparam logic [1:0] CD_ITER = 2'd1;
  localparam logic [1:0] CD_DONE = 2'd2;

  function automatic logic signed [35:0] shr_tz(input logic signed [35:0] v,
                                               input logic [3:0] k);
    logic signed [35:0] m;
    m = v[35] ? -v : v;
    m = m >>> k;
    return v[35] ? -m : m;
  endfunction

  function automatic logic [38:0] div_step(input logic [32:0] n, input logic [5:0] r,
                                           input logic [5:0] d);
    logic [6:0]  t;
    logic [38:0] res;
    t = {r, n[32]};
    if (t >= {1'b0, d}) begin
      res = {n[31:0], 1'b1, 6'(t - {1'b0, d})};
    end else begin
      res = {n[31:0], 1'b0, t[5:0]};
    end
    return res;
  endfunction

  // input buffer so a request can wait while the previous one is worked on
  logic               buf_valid_q;
  logic [31:0]        bsx_q, bsy_q;
  logic signed [32:0] bdx_q, bdy_q;
  logic               take;

  logic [2:0]  state_q;
  logic [31:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [31:0] sx_q, sy_q;
  logic [DenW-1:0] den_q;
  logic [31:0] vv_q;
  logic [63:0] sq_q;
  logic [65:0] rad_q;
  logic [35:0] srem_q;
  logic [32:0] sroot_q;
  logic [5:0]  scnt_q;
  logic [1:0]  cd_q;
  logic [31:0] cx_q, cy_q;
  logic signed [35:0] x_q, y_q;
  logic signed [19:0] z_q;
  logic [3:0]  k_q;
  logic [15:0] hd_q;
  logic [32:0] nx_q, ny_q, nd_q;
  logic [5:0]  remx_q, remy_q, remd_q;
  logic [5:0]  dcnt_q;
  logic [32:0] dist_q;
  logic        par_valid_q;
  run_t        par_q;

  logic [31:0] mul_op;
  logic [63:0] prod64;
  logic [48:0] dist_a;
  logic        tri_w;
  logic [15:0] a_eff;
  isq_t        sq_nxt;
  logic signed [35:0] xs, ys;
  logic [38:0] dvx, dvy, dvd;
  logic [18:0] zc;
  logic [16:0] hr;
  logic [15:0] hmag, hq, hsign;
  logic [32:0] absx, absy;

  assign take       = (state_q == S_IDLE) && buf_valid_q;
  assign in_ready_o = !buf_valid_q || take;
  assign a_eff      = eff_accel(cfg_i.max_accel);

  assign mul_op = (state_q == S_SQX) ? ax_q : ay_q;
  assign prod64 = 64'(mul_op) * 64'(mul_op);
  assign dist_a = 49'(dist_q) * 49'(a_eff);
  assign tri_w  = 49'({vv_q, 8'b0}) > dist_a;
  assign sq_nxt = isq_step(srem_q, rad_q[65:64], sroot_q);
  assign xs     = shr_tz(x_q, k_q);
  assign ys     = shr_tz(y_q, k_q);
  assign dvx    = div_step(nx_q, remx_q, den_q);
  assign dvy    = div_step(ny_q, remy_q, den_q);
  assign dvd    = div_step(nd_q, remd_q, den_q);
  assign absx   = bdx_q[32] ? 33'(-bdx_q) : 33'(bdx_q);
  assign absy   = bdy_q[32] ? 33'(-bdy_q) : 33'(bdy_q);

  // round the cordic angle to q2.13, clamp, then mirror into the quadrant
  always_comb begin
    zc = z_q[19] ? 19'd0 : 19'(z_q);
    hr = 17'(({1'b0, zc} + 20'd4) >> 3);
    hmag = (hr > 17'(HALF_PI_Q13)) ? HALF_PI_Q13 : hr[15:0];
    if (ay_q == 32'd0) begin
      hq = 16'd0;
    end else if (ax_q == 32'd0) begin
      hq = HALF_PI_Q13;
    end else begin
      hq = hmag;
    end
    if (negx_q) begin
      hq = PI_Q13 - hq;
    end
    hsign = negy_q ? 16'(-hq) : hq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      buf_valid_q <= 1'b1;
    end else if (take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      bsx_q <= start_x_i;
      bsy_q <= start_y_i;
      bdx_q <= $signed({goal_x_i[31], goal_x_i}) - $signed({start_x_i[31], start_x_i});
      bdy_q <= $signed({goal_y_i[31], goal_y_i}) - $signed({start_y_i[31], start_y_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      par_valid_q <= 1'b0;
      cd_q        <= CD_DONE;
    end else begin
      if (par_valid_q && par_ready_i) begin
        par_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          state_q <= S_SQY;
        end
        S_SQY: begin
          state_q <= S_RUN;
          cd_q    <= ((ax_q == 32'd0) || (ay_q == 32'd0)) ? CD_DONE : CD_NORM;
        end
        S_RUN: begin
          case (cd_q)
            CD_NORM: begin
              if (cx_q[31] || cy_q[31]) begin
                cd_q <= CD_ITER;
              end
            end
            CD_ITER: begin
              if (k_q == 4'(CordicSteps - 1)) begin
                cd_q <= CD_DONE;
              end
            end
            default: cd_q <= CD_DONE;
          endcase
          if ((scnt_q == 6'(SqrtSteps)) && (cd_q == CD_DONE)) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_q == 6'(DivSteps - 1)) begin
            state_q <= S_TRI;
          end
        end
        S_TRI: begin
          if (!par_valid_q || par_ready_i) begin
            par_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (take) begin
          ax_q   <= absx[31:0];
          ay_q   <= absy[31:0];
          negx_q <= bdx_q[32];
          negy_q <= bdy_q[32];
          sx_q   <= bsx_q;
          sy_q   <= bsy_q;
          den_q  <= run_den(cfg_i.point_count);
          vv_q   <= 32'(cfg_i.cruise_velocity) * 32'(cfg_i.cruise_velocity);
        end
      end
      S_SQX: begin
        sq_q <= prod64;
      end
      S_SQY: begin
        rad_q   <= {1'b0, 65'(sq_q) + 65'(prod64)};
        srem_q  <= '0;
        sroot_q <= '0;
        scnt_q  <= '0;
        cx_q    <= ax_q;
        cy_q    <= ay_q;
      end
      S_RUN: begin
        if (scnt_q != 6'(SqrtSteps)) begin
          srem_q  <= sq_nxt.rem;
          sroot_q <= sq_nxt.root;
          rad_q   <= {rad_q[63:0], 2'b00};
          scnt_q  <= scnt_q + 6'd1;
        end
        if (cd_q == CD_NORM) begin
          if (cx_q[31] || cy_q[31]) begin
            x_q <= $signed({4'b0, cx_q});
            y_q <= $signed({4'b0, cy_q});
            z_q <= '0;
            k_q <= '0;
          end else begin
            cx_q <= {cx_q[30:0], 1'b0};
            cy_q <= {cy_q[30:0], 1'b0};
          end
        end else if (cd_q == CD_ITER) begin
          if (y_q > 36'sd0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + $signed({4'b0, CORDIC_ANGLE[k_q]});
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - $signed({4'b0, CORDIC_ANGLE[k_q]});
          end
          k_q <= k_q + 4'd1;
        end
        if ((scnt_q == 6'(SqrtSteps)) && (cd_q == CD_DONE)) begin
          dist_q <= sroot_q;
          nd_q   <= sroot_q;
          nx_q   <= {1'b0, ax_q};
          ny_q   <= {1'b0, ay_q};
          remx_q <= '0;
          remy_q <= '0;
          remd_q <= '0;
          dcnt_q <= '0;
          hd_q   <= hsign;
        end
      end
      S_DIV: begin
        nx_q   <= dvx[38:6];
        remx_q <= dvx[5:0];
        ny_q   <= dvy[38:6];
        remy_q <= dvy[5:0];
        nd_q   <= dvd[38:6];
        remd_q <= dvd[5:0];
        dcnt_q <= dcnt_q + 6'd1;
      end
      S_TRI: begin
        if (!par_valid_q || par_ready_i) begin
          par_q.sx       <= sx_q;
          par_q.sy       <= sy_q;
          par_q.neg_x    <= negx_q;
          par_q.neg_y    <= negy_q;
          par_q.qx       <= nx_q;
          par_q.rx       <= remx_q;
          par_q.qy       <= ny_q;
          par_q.ry       <= remy_q;
          par_q.qd       <= nd_q;
          par_q.rd       <= remd_q;
          par_q.span     <= dist_q;
          par_q.heading  <= hd_q;
          par_q.triangle <= tri_w;
          par_q.den      <= den_q;
          par_q.vv       <= vv_q;
        end
      end
      default: ;
    endcase
  end

  assign par_valid_o = par_valid_q;
  assign par_o       = par_q;

endmodule
`default_nettype wire

FILE: sv/slt_gen.sv
// waypoint sequencer and pipelined profile datapath, one waypoint per cycle unless out_ready_i stalls the output
`default_nettype none
`include "straight_line_trapezoid_trajectory_macros.svh"
module slt_gen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::cfg_t cfg_i,
  input  logic          par_valid_i,
  output logic          par_ready_o,
  input  slt_pkg::run_t par_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   way_x_o,
  output logic [31:0]   way_y_o,
  output logic [15:0]   heading_o,
  output logic [15:0]   stamp_ms_o,
  output logic [32:0]   travelled_o,
  output logic [15:0]   speed_o,
  output logic [16:0]   accel_o,
  output logic          last_o
);
  import slt_pkg::*;

  localparam int SqStages = 5;
  localparam int SqPer    = 5;

  typedef struct packed {
    logic [31:0]     way_x;
    logic [31:0]     way_y;
    logic [15:0]     heading;
    logic [DenW-1:0] idx;
    logic [32:0]     s;
    logic [32:0]     span;
    logic            triangle;
    logic            last;
  } p1_t;

  typedef struct packed {
    logic [31:0] way_x;
    logic [31:0] way_y;
    logic [15:0] heading;
    logic [15:0] stamp;
    logic [32:0] s;
    logic [32:0] span;
    logic        triangle;
    logic        last;
    logic [48:0] sa;
    logic [48:0] ra;
  } p2_t;

  typedef struct packed {
    logic [31:0] way_x;
    logic [31:0] way_y;
    logic [15:0] heading;
    logic [15:0] stamp;
    logic [32:0] s;
    logic        last;
    logic        cruise;
    logic [16:0] acc;
    logic [49:0] rad;
    logic [27:0] rem;
    logic [24:0] root;
  } sq_t;

  function automatic logic [38:0] lerp_step(input logic [32:0] q, input logic [5:0] r,
                                            input logic [32:0] q0, input logic [5:0] r0,
                                            input logic [5:0] d);
    logic [6:0]  t;
    logic [38:0] res;
    t = {1'b0, r} + {1'b0, r0};
    if (t >= {1'b0, d}) begin
      res = {q + q0 + 33'd1, 6'(t - {1'b0, d})};
    end else begin
      res = {q + q0, t[5:0]};
    end
    return res;
  endfunction

  logic en, load, issue, last_idx;
  logic active_q;
  run_t run_q;
  logic [DenW-1:0] idx_q;
  logic [32:0] qx_q, qy_q, qs_q;
  logic [5:0]  rx_q, ry_q, rs_q;
  logic [38:0] stx, sty, sts;
  logic [15:0] a_eff;
  logic        rem_ok;

  logic v1_q, v2_q, ov_q;
  p1_t  p1_d, p1_q;
  p2_t  p2_d, p2_q;
  sq_t  sq_d;
  sq_t  sq_q [SqStages+1];
  logic vq_q [SqStages+1];

  logic [32:0] rem_s;
  logic [38:0] ramp;
  logic        ph_acc, ph_cru;
  logic [15:0] spd;

  logic [31:0] ox_q, oy_q;
  logic [15:0] oh_q, ost_q, osp_q;
  logic [32:0] otr_q;
  logic [16:0] oac_q;
  logic        olast_q;

  assign en          = !ov_q || out_ready_i;
  assign last_idx    = (idx_q == run_q.den);
  assign issue       = active_q && en;
  assign par_ready_o = !active_q || (issue && last_idx);
  assign load        = par_valid_i && par_ready_o;
  assign a_eff       = eff_accel(cfg_i.max_accel);

  assign stx = lerp_step(qx_q, rx_q, run_q.qx, run_q.rx, run_q.den);
  assign sty = lerp_step(qy_q, ry_q, run_q.qy, run_q.ry, run_q.den);
  assign sts = lerp_step(qs_q, rs_q, run_q.qd, run_q.rd, run_q.den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load) begin
      active_q <= 1'b1;
    end else if (issue && last_idx) begin
      active_q <= 1'b0;
    end
  end

  // running quotient and remainder of i*d + den/2 over den
  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= par_i;
      idx_q <= '0;
      qx_q  <= '0;
      qy_q  <= '0;
      qs_q  <= '0;
      rx_q  <= par_i.den >> 1;
      ry_q  <= par_i.den >> 1;
      rs_q  <= par_i.den >> 1;
    end else if (issue) begin
      idx_q <= idx_q + 1'b1;
      qx_q  <= stx[38:6];
      rx_q  <= stx[5:0];
      qy_q  <= sty[38:6];
      ry_q  <= sty[5:0];
      qs_q  <= sts[38:6];
      rs_q  <= sts[5:0];
    end
  end

  always_comb begin
    p1_d.way_x    = run_q.sx + (run_q.neg_x ? 32'(-qx_q[31:0]) : qx_q[31:0]);
    p1_d.way_y    = run_q.sy + (run_q.neg_y ? 32'(-qy_q[31:0]) : qy_q[31:0]);
    p1_d.heading  = run_q.heading;
    p1_d.idx      = idx_q;
    p1_d.s        = qs_q;
    p1_d.span     = run_q.span;
    p1_d.triangle = run_q.triangle;
    p1_d.last     = last_idx;
  end

  always_comb begin
    rem_s         = p1_q.span - p1_q.s;
    p2_d.way_x    = p1_q.way_x;
    p2_d.way_y    = p1_q.way_y;
    p2_d.heading  = p1_q.heading;
    p2_d.stamp    = 16'(16'(p1_q.idx) * 16'(cfg_i.time_step_ms));
    p2_d.s        = p1_q.s;
    p2_d.span     = p1_q.span;
    p2_d.triangle = p1_q.triangle;
    p2_d.last     = p1_q.last;
    p2_d.sa       = 49'(p1_q.s) * 49'(a_eff);
    p2_d.ra       = 49'(rem_s) * 49'(a_eff);
  end

  // phase decision; the ramp distance is v*v*128 in the units of s*a
  always_comb begin
    ramp = {run_q.vv, 7'b0};
    ph_acc = 1'b0;
    ph_cru = 1'b0;
    if (p2_q.triangle) begin
      ph_acc = {p2_q.s, 1'b0} < {1'b0, p2_q.span};
    end else if (p2_q.sa < 49'(ramp)) begin
      ph_acc = 1'b1;
    end else if (p2_q.ra > 49'(ramp)) begin
      ph_cru = 1'b1;
    end
    sq_d.way_x   = p2_q.way_x;
    sq_d.way_y   = p2_q.way_y;
    sq_d.heading = p2_q.heading;
    sq_d.stamp   = p2_q.stamp;
    sq_d.s       = p2_q.s;
    sq_d.last    = p2_q.last;
    sq_d.cruise  = ph_cru || !cfg_i.trapezoid_mode;
    if (!cfg_i.trapezoid_mode || ph_cru) begin
      sq_d.acc = '0;
    end else if (ph_acc) begin
      sq_d.acc = {1'b0, a_eff};
    end else begin
      sq_d.acc = 17'(-{1'b0, a_eff});
    end
    sq_d.rad  = ph_acc ? {p2_q.sa, 1'b0} : {p2_q.ra, 1'b0};
    sq_d.rem  = '0;
    sq_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue;
      v2_q <= v1_q;
      ov_q <= vq_q[SqStages];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q[0] <= 1'b0;
    end else if (en) begin
      vq_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      sq_q[0] <= sq_d;
    end
  end

  // square root of 2*a*s, or of 2*a*(span-s) outside the accelerating phase, five digits per stage
  for (genvar g = 1; g <= SqStages; g++) begin : g_sqrt
    sq_t nxt;
    always_comb begin
      isq_t st;
      nxt = sq_q[g-1];
      for (int j = 0; j < SqPer; j++) begin
        st       = isq_step({8'b0, nxt.rem}, nxt.rad[49:48], {8'b0, nxt.root});
        nxt.rem  = st.rem[27:0];
        nxt.root = st.root[24:0];
        nxt.rad  = {nxt.rad[47:0], 2'b00};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq_q[g] <= 1'b0;
      end else if (en) begin
        vq_q[g] <= vq_q[g-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g] <= nxt;
      end
    end
  end

  always_comb begin
    if (sq_q[SqStages].cruise) begin
      spd = cfg_i.cruise_velocity;
    end else if (|sq_q[SqStages].root[24:20]) begin
      spd = 16'hFFFF;
    end else begin
      spd = sq_q[SqStages].root[19:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q    <= sq_q[SqStages].way_x;
      oy_q    <= sq_q[SqStages].way_y;
      oh_q    <= sq_q[SqStages].heading;
      ost_q   <= sq_q[SqStages].stamp;
      otr_q   <= sq_q[SqStages].s;
      osp_q   <= spd;
      oac_q   <= sq_q[SqStages].acc;
      olast_q <= sq_q[SqStages].last;
    end
  end

  assign out_valid_o = ov_q;
  assign way_x_o     = ox_q;
  assign way_y_o     = oy_q;
  assign heading_o   = oh_q;
  assign stamp_ms_o  = ost_q;
  assign travelled_o = otr_q;
  assign speed_o     = osp_q;
  assign accel_o     = oac_q;
  assign last_o      = olast_q;

  assign rem_ok = (rx_q < run_q.den) && (ry_q < run_q.den) && (rs_q < run_q.den);

  `SLT_ASSERT(a_idx_range, active_q |-> (idx_q <= run_q.den), "waypoint index beyond run end")
  `SLT_ASSERT(a_rem_range, active_q |-> rem_ok, "step remainder not normalized")
  `SLT_ASSERT_NEXT(a_run_end, issue && last_idx && !load, !active_q, "sequencer ran past final waypoint")
  `SLT_ASSERT(a_travel, v2_q |-> (p2_q.s <= p2_q.span), "path length exceeds distance")

endmodule
`default_nettype wire

FILE: sv/straight_line_trapezoid_trajectory.sv
// Straight-line trajectory generator. Each accepted start/goal beat starts a run of point_count
// waypoints (clamped to 2..64) evenly spaced on the segment, each with heading, timestamp,
// path length and a constant, trapezoidal or triangular speed and acceleration. A request first
// passes an iterative setup unit: a bit-serial square root for the distance running next to the
// normalize-and-16-step cordic for the heading, then restoring division of the deltas and the
// distance by the clamped point_count-1 in three parallel dividers. Waypoints then leave a
// 9-stage pipeline (step accumulators, multipliers, phase compare, five stages of square root,
// output register) at one per cycle while out_ready_i does not stall the output. The next
// request is buffered and set up while the current run streams out.
`default_nettype none
module straight_line_trapezoid_trajectory (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [slt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [slt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           start_x_i,
  input  logic signed [31:0]           start_y_i,
  input  logic signed [31:0]           goal_x_i,
  input  logic signed [31:0]           goal_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           way_x_o,
  output logic signed [31:0]           way_y_o,
  output logic signed [15:0]           heading_o,
  output logic [15:0]                  stamp_ms_o,
  output logic [32:0]                  travelled_o,
  output logic [15:0]                  speed_o,
  output logic signed [16:0]           accel_o,
  output logic                         last_o
);
  import slt_pkg::*;

  cfg_t cfg_q;
  logic par_valid, par_ready;
  run_t par;
  logic [31:0] wx, wy;
  logic [15:0] hd;
  logic [16:0] ac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count     <= 7'd30;
      cfg_q.time_step_ms    <= 10'd100;
      cfg_q.cruise_velocity <= 16'd256;
      cfg_q.max_accel       <= 16'd256;
      cfg_q.trapezoid_mode  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT: cfg_q.point_count     <= cfg_data_i[6:0];
        CFG_TIME_STEP:   cfg_q.time_step_ms    <= cfg_data_i[9:0];
        CFG_CRUISE:      cfg_q.cruise_velocity <= cfg_data_i;
        CFG_MAX_ACCEL:   cfg_q.max_accel       <= cfg_data_i;
        CFG_TRAP_MODE:   cfg_q.trapezoid_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  slt_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .goal_x_i    (goal_x_i),
    .goal_y_i    (goal_y_i),
    .par_valid_o (par_valid),
    .par_ready_i (par_ready),
    .par_o       (par)
  );

  slt_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .par_valid_i (par_valid),
    .par_ready_o (par_ready),
    .par_i       (par),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .way_x_o     (wx),
    .way_y_o     (wy),
    .heading_o   (hd),
    .stamp_ms_o  (stamp_ms_o),
    .travelled_o (travelled_o),
    .speed_o     (speed_o),
    .accel_o     (ac),
    .last_o      (last_o)
  );

  assign way_x_o   = $signed(wx);
  assign way_y_o   = $signed(wy);
  assign heading_o = $signed(hd);
  assign accel_o   = $signed(ac);

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench for the straight-line trapezoid trajectory generator
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import slt_pkg::*;

  typedef struct {
    logic signed [31:0] sx, sy, gx, gy;
    bit                 drain;
  } request_t;

  typedef struct {
    logic signed [31:0] x, y;
    logic signed [15:0] hd;
    logic [15:0]        stamp;
    logic [32:0]        trav;
    logic [15:0]        spd;
    logic signed [16:0] acc;
    logic               lst;
  } waypoint_t;

  localparam int WatchLimit = 5000;
  localparam int SettleCycles = 200;
  localparam int HoldCycles = 600;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic signed [31:0] start_x_i = 0, start_y_i = 0, goal_x_i = 0, goal_y_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic signed [31:0] way_x_o, way_y_o;
  logic signed [15:0] heading_o;
  logic [15:0] stamp_ms_o, speed_o;
  logic [32:0] travelled_o;
  logic signed [16:0] accel_o;
  logic last_o;

  straight_line_trapezoid_trajectory DUT (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // mirrored register file
  logic [6:0]  pts_reg;
  logic [9:0]  step_reg;
  logic [15:0] vel_reg, acc_reg;
  logic        trap_reg;

  request_t  pending_q[$];
  waypoint_t waypoint_q[$];
  int errors = 0, n_req = 0, n_wp = 0, n_tri = 0, n_trap = 0, n_const = 0;
  int idle_cnt = 0, hold_asked = 0, hold_seen = 0;
  bit burst = 0;

  localparam longint CORDIC_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                          256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint unsigned floor_sqrt(logic [127:0] v);
    logic [63:0] root, t;
    logic [127:0] sq;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      sq = 128'(t) * 128'(t);
      if (sq <= v) root = t;
    end
    return root;
  endfunction

  function automatic longint trunc_shift(longint v, int k);
    return (v >= 0) ? (v >>> k) : -((-v) >>> k);
  endfunction

  function automatic longint seg_heading(longint dx, longint dy);
    longint ax, ay, x, y, z, h, xs, ys;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    if (ay == 0) h = 0;
    else if (ax == 0) h = 12868;
    else begin
      while (ax < 64'h8000_0000 && ay < 64'h8000_0000) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      x = ax;
      y = ay;
      for (int k = 0; k < 16; k++) begin
        xs = trunc_shift(x, k);
        ys = trunc_shift(y, k);
        if (y > 0) begin
          x += ys; y -= xs; z += CORDIC_TAB[k];
        end else begin
          x -= ys; y += xs; z -= CORDIC_TAB[k];
        end
      end
      if (z < 0) z = 0;
      h = (z + 4) >>> 3;
      if (h > 12868) h = 12868;
    end
    if (dx < 0) h = 25736 - h;
    if (dy < 0) h = -h;
    return h;
  endfunction

  function automatic longint unsigned ramp_speed(longint unsigned a, longint unsigned s);
    longint unsigned r;
    r = floor_sqrt(128'(2 * a * s)) >> 4;
    return r > 65535 ? 65535 : r;
  endfunction

  function automatic longint interp(longint d, longint unsigned i, longint unsigned den);
    longint unsigned m;
    longint q;
    m = (d < 0 ? -d : d) * i;
    q = longint'((m + den / 2) / den);
    return d < 0 ? -q : q;
  endfunction

  // expected waypoints of one accepted request
  task automatic plan_waypoints(request_t r);
    longint dx, dy, hd;
    longint unsigned ax, ay, span, n, den, a, v, ramp128, s, rem;
    logic [127:0] sumsq;
    bit tri_prof;
    int phase;
    waypoint_t w;
    dx = longint'(r.gx) - longint'(r.sx);
    dy = longint'(r.gy) - longint'(r.sy);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sumsq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    span = floor_sqrt(sumsq);
    if (span > 64'h1_FFFF_FFFF) span = 64'h1_FFFF_FFFF;
    n = pts_reg < 2 ? 2 : (pts_reg > MaxPoints ? MaxPoints : pts_reg);
    den = n - 1;
    a = acc_reg == 0 ? 1 : acc_reg;
    v = vel_reg;
    ramp128 = v * v * 128;
    hd = seg_heading(dx, dy);
    tri_prof = (v * v * 256) > span * a;
    if (!trap_reg) n_const++;
    else if (tri_prof) n_tri++;
    else n_trap++;
    for (longint unsigned i = 0; i < n; i++) begin
      s = (span * i + den / 2) / den;
      if (s > span) s = span;
      rem = span - s;
      if (tri_prof) phase = (2 * s < span) ? 1 : -1;
      else if (s * a < ramp128) phase = 1;
      else if (rem * a > ramp128) phase = 0;
      else phase = -1;
      if (!trap_reg || phase == 0) begin
        w.spd = v; w.acc = 0;
      end else if (phase > 0) begin
        w.spd = ramp_speed(a, s); w.acc = 17'(a);
      end else begin
        w.spd = ramp_speed(a, rem); w.acc = -17'(a);
      end
      w.x = 32'(longint'(r.sx) + interp(dx, i, den));
      w.y = 32'(longint'(r.sy) + interp(dy, i, den));
      w.hd = 16'(hd);
      w.stamp = 16'(i * step_reg);
      w.trav = 33'(s);
      w.lst = (i == den);
      waypoint_q = {waypoint_q, w};
    end
  endtask

  task automatic report(string fld, longint unsigned got, longint unsigned want);
    errors++;
    $display("waypoint %0d: %s got %0h want %0h", n_wp, fld, got, want);
  endtask

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    request_t r;
    int g;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        plan_waypoints(pending_q.pop_front());
        n_req++;
        g = burst ? 0 : $urandom_range(0, 13);
        if (g == 0 && pending_q.size() > 0 && !pending_q[0].drain) begin
          r = pending_q[0];
          start_x_i <= r.sx; start_y_i <= r.sy; goal_x_i <= r.gx; goal_y_i <= r.gy;
        end else begin
          in_valid_i <= 0;
          gap <= g;
        end
      end else if (!in_valid_i && pending_q.size() > 0) begin
        if (gap > 0) gap <= gap - 1;
        else if (!(pending_q[0].drain && waypoint_q.size() != 0)) begin
          r = pending_q[0];
          start_x_i <= r.sx; start_y_i <= r.sy; goal_x_i <= r.gx; goal_y_i <= r.gy;
          in_valid_i <= 1;
        end
      end
    end
  end

  // monitor
  int stall = 0, hold_left = 0;
  always @(posedge clk_i) begin
    waypoint_t w;
    logic rdy;
    int st, hl;
    st = stall;
    hl = hold_left;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (waypoint_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          w = waypoint_q.pop_front();
          if (way_x_o !== w.x) report("way_x", 32'(way_x_o), 32'(w.x));
          if (way_y_o !== w.y) report("way_y", 32'(way_y_o), 32'(w.y));
          if (heading_o !== w.hd) report("heading", 16'(heading_o), 16'(w.hd));
          if (stamp_ms_o !== w.stamp) report("stamp_ms", stamp_ms_o, w.stamp);
          if (travelled_o !== w.trav) report("travelled", travelled_o, w.trav);
          if (speed_o !== w.spd) report("speed", speed_o, w.spd);
          if (accel_o !== w.acc) report("accel", 17'(accel_o), 17'(w.acc));
          if (last_o !== w.lst) report("last", last_o, w.lst);
        end
        n_wp++;
        st = burst ? 0 : $urandom_range(0, 13);
      end
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hl = HoldCycles;
      end
      if (hl > 0) begin
        hl--; rdy = 0;
      end else if (st > 0) begin
        st--; rdy = 0;
      end else rdy = 1;
      stall <= st;
      hold_left <= hl;
      out_ready_i <= rdy;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("timeout after %0d idle cycles", idle_cnt);
      $display("straight_line_trapezoid_trajectory: mismatch");
      $finish;
    end
  end

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    case (idx)
      CFG_POINT_COUNT: pts_reg = val[6:0];
      CFG_TIME_STEP:   step_reg = val[9:0];
      CFG_CRUISE:      vel_reg = val;
      CFG_MAX_ACCEL:   acc_reg = val;
      CFG_TRAP_MODE:   trap_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic setup_regs(int pc, int st, int vel, int acc, int md);
    reg_write(CFG_POINT_COUNT, 16'(pc));
    reg_write(CFG_TIME_STEP, 16'(st));
    reg_write(CFG_CRUISE, 16'(vel));
    reg_write(CFG_MAX_ACCEL, 16'(acc));
    reg_write(CFG_TRAP_MODE, 16'(md));
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic queue_req(logic [31:0] sx, logic [31:0] sy, logic [31:0] gx, logic [31:0] gy);
    request_t r;
    r.sx = sx; r.sy = sy; r.gx = gx; r.gy = gy; r.drain = 0;
    pending_q = {pending_q, r};
  endtask

  task automatic queue_random();
    logic [31:0] sx, sy, dx, dy;
    int kind;
    kind = $urandom_range(0, 99);
    sx = $urandom; sy = $urandom;
    if (kind < 20) begin
      queue_req(sx, sy, $urandom, $urandom);
      return;
    end
    sx = $signed(sx) >>> $urandom_range(0, 14);
    sy = $signed(sy) >>> $urandom_range(0, 14);
    dx = $signed(32'($urandom)) >>> $urandom_range(4, 22);
    dy = $signed(32'($urandom)) >>> $urandom_range(4, 22);
    if (kind < 35) begin
      // short hops to favour a triangular profile
      dx = $signed(dx) >>> 10; dy = $signed(dy) >>> 10;
    end else if (kind < 43) begin
      dx = 0; dy = 0;
    end else if (kind < 50) dx = 0;
    else if (kind < 57) dy = 0;
    queue_req(sx, sy, sx + dx, sy + dy);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || waypoint_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    pts_reg = 30; step_reg = 100; vel_reg = 256; acc_reg = 256; trap_reg = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed corners under reset settings
    queue_req(0, 0, 0, 0);
    queue_req(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    queue_req(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    queue_req(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    queue_req(32'h0001_0000, 0, 32'hFFFF_0000, 0);
    queue_req(0, 0, 32'hFFFF_0000, 32'hFFFF_0000);
    queue_req(0, 0, 32'h0003_0000, 32'hFFFC_0000);
    queue_req(0, 0, 1, 1);
    queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002);
    queue_req(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    queue_req(0, 0, 32'h0100_0000, 32'h0000_0001);
    queue_req(0, 0, 32'h0000_0001, 32'h0100_0000);
    queue_req(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: setup_regs(2, 1, 0, 0, 1);
        1: setup_regs(64, 1023, 65535, 65535, 1);
        2: setup_regs(127, 0, 256, 1, 0);
        3: setup_regs(0, 1000, 65535, 1, 1);
        4: setup_regs(1, 7, 40000, 3, 1);
        5: setup_regs(64, 1000, 0, 65535, 0);
        default: setup_regs($urandom_range(2, 40), $urandom_range(0, 1023), $urandom,
                            $urandom_range(0, 65535), $urandom_range(0, 1));
      endcase
      burst = (ph % 3 == 1);
      // small-coordinate directed probes per setting
      queue_req(0, 0, 0, 0);
      queue_req(0, 0, 32'h0000_8000, 32'h0000_0000);
      for (int k = 0; k < 20; k++) queue_random();
      if (ph == 4) hold_asked++;
      if (ph == 7) begin
        request_t r;
        r = pending_q[10];
        r.drain = 1;
        pending_q[10] = r;
      end
      wait_idle();
    end

    $display("%0d requests, %0d waypoints checked", n_req, n_wp);
    $display("profiles: %0d triangular, %0d trapezoidal, %0d constant speed",
             n_tri, n_trap, n_const);
    if (errors == 0 && waypoint_q.size() == 0) begin
      $display("straight_line_trapezoid_trajectory: match");
    end else begin
      if (waypoint_q.size() != 0) $display("%0d waypoints never arrived", waypoint_q.size());
      $display("straight_line_trapezoid_trajectory: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: straight_line_trapezoid_trajectory.f
+incdir+sv
sv/slt_pkg.sv
sv/slt_setup.sv
sv/slt_gen.sv
sv/straight_line_trapezoid_trajectory.sv
verif/testbench.sv
